// ===== hw/rtl/pwl_lin_pkg.sv =====
// Shared types, codes and reset calibration table of the sensor linearizer.
package pwl_lin_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int FLOW_W       = 12;
    localparam int IDX_W        = 4;
    localparam int PROD_W       = SAMPLE_W + FLOW_W;
    localparam int QUOT_BITS    = 12;
    localparam int DIV_CNT_W    = 4;
    localparam int RESET_POINTS = 16;
    localparam int RST_ARG_W    = 7;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [FLOW_W-1:0]   flow_t;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    localparam flow_t FLOW_MAX = {FLOW_W{1'b1}};

    localparam sample_t RESET_SENSOR [RESET_POINTS] = '{
        12'd98,  12'd100, 12'd107, 12'd113, 12'd125, 12'd139, 12'd158, 12'd181,
        12'd204, 12'd238, 12'd274, 12'd326, 12'd385, 12'd454, 12'd536, 12'd600
    };

    // Entries past the reset table repeat its last point.
    function automatic sample_t reset_sensor(input logic [RST_ARG_W-1:0] k);
        logic [IDX_W-1:0] kc;
        kc = (k > RST_ARG_W'(RESET_POINTS - 1)) ? IDX_W'(RESET_POINTS - 1) : k[IDX_W-1:0];
        return RESET_SENSOR[kc];
    endfunction

    function automatic flow_t reset_flow(input logic [RST_ARG_W-1:0] k);
        logic [IDX_W-1:0] kc;
        kc = (k > RST_ARG_W'(RESET_POINTS - 1)) ? IDX_W'(RESET_POINTS - 1) : k[IDX_W-1:0];
        return {kc, 8'h00};
    endfunction

endpackage

// ===== hw/rtl/piecewise_linear_sensor_linearizer_unit.sv =====
// Piecewise-linear sensor linearizer: serial segment scan, multiply and bit-serial divide.
//
//  channel | dir | tdata (low bit up)                                    | tuser
//  s_      | in  | sample[11:0] entry_index[15:12] entry_sensor[27:16]   | op
//          |     | entry_flow[39:28]                                     |
//  m_      | out | flow[11:0], zero fill[15:12]                          | in_range
//
// A write transaction writes one table entry. A convert transaction reads one entry per cycle,
// scanning until a segment holds the sample or the last entry is read (out of range),
// then a multiply and a bit-serial divide (both skipped on a zero-width segment) and the
// output step. s_tready is low meanwhile, and a stalled result holds the block in its last
// step. Synchronous reset restores the table.
module piecewise_linear_sensor_linearizer_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // sample, entry_index, entry_sensor, entry_flow
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // flow, zero fill
    output logic        m_tuser    // in_range
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int EW = ((IW > pwl_lin_pkg::IDX_W) ? IW : pwl_lin_pkg::IDX_W) + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam int FW = pwl_lin_pkg::FLOW_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // input fields
    pwl_lin_pkg::sample_t          s_sample;
    logic [pwl_lin_pkg::IDX_W-1:0] s_entry_index;
    pwl_lin_pkg::sample_t          s_entry_sensor;
    pwl_lin_pkg::flow_t            s_entry_flow;

    assign s_sample       = s_tdata[11:0];
    assign s_entry_index  = s_tdata[15:12];
    assign s_entry_sensor = s_tdata[27:16];
    assign s_entry_flow   = s_tdata[39:28];

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // calibration memory
    pwl_lin_pkg::sample_t sens_mem [TABLE_ENTRIES];
    pwl_lin_pkg::flow_t   flow_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    pwl_lin_pkg::sample_t sens_q_reg;
    pwl_lin_pkg::flow_t   flow_q_reg;
    logic                 valid_q_reg;

    logic [IW-1:0] rd_idx_reg;
    logic [IW-1:0] data_idx_reg;
    logic          data_ok_reg;

    pwl_lin_pkg::sample_t x_reg;
    pwl_lin_pkg::sample_t prev_sens_reg;
    pwl_lin_pkg::flow_t   prev_flow_reg;

    pwl_lin_pkg::flow_t   y1_reg;
    pwl_lin_pkg::flow_t   dy_reg;
    pwl_lin_pkg::sample_t dx_reg;
    pwl_lin_pkg::sample_t den_reg;
    logic                 neg_reg;

    logic [FW-1:0]                     rem_reg;
    logic [pwl_lin_pkg::QUOT_BITS-1:0] quo_reg;
    logic [pwl_lin_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    pwl_lin_pkg::flow_t res_flow_reg;
    logic               res_in_reg;
    pwl_lin_pkg::flow_t out_flow_reg;
    logic               out_in_reg;
    logic               m_tvalid_reg;

    logic s_accept;
    logic conv_accept;
    logic wr_en;
    logic [EW-1:0] wr_wide;
    logic [IW-1:0] wr_addr;
    logic out_free;

    pwl_lin_pkg::sample_t cur_sens;
    pwl_lin_pkg::flow_t   cur_flow;
    logic hit;
    logic last;
    logic den_zero;

    logic [pwl_lin_pkg::PROD_W-1:0]    prod;
    logic [FW:0]                       div_trial;
    logic                              div_ge;
    logic [FW:0]                       div_diff;
    logic [FW-1:0]                     rem_next;
    logic [pwl_lin_pkg::QUOT_BITS-1:0] quo_next;
    logic [FW:0]                       sum_w;
    logic [FW:0]                       diff_w;
    pwl_lin_pkg::flow_t                res_value;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign conv_accept = s_accept && (s_tuser == pwl_lin_pkg::OP_CONVERT);
    assign wr_wide     = EW'(s_entry_index);
    assign wr_addr     = wr_wide[IW-1:0];
    assign wr_en       = s_accept && (s_tuser == pwl_lin_pkg::OP_WRITE)
                         && (wr_wide < EW'(TABLE_ENTRIES));
    assign out_free    = !m_tvalid_reg || m_tready;

    // never-written entries read their reset value
    assign cur_sens = valid_q_reg ? sens_q_reg
                    : pwl_lin_pkg::reset_sensor(pwl_lin_pkg::RST_ARG_W'(data_idx_reg));
    assign cur_flow = valid_q_reg ? flow_q_reg
                    : pwl_lin_pkg::reset_flow(pwl_lin_pkg::RST_ARG_W'(data_idx_reg));

    assign hit  = data_ok_reg && (data_idx_reg != '0)
                  && (x_reg >= prev_sens_reg) && (x_reg <= cur_sens);
    assign last = data_ok_reg && (data_idx_reg == LAST_IDX);
    assign den_zero = (cur_sens == prev_sens_reg);

    assign prod = dy_reg * dx_reg;

    // one restoring divide step; the quotient fits QUOT_BITS since dx <= den
    assign div_trial = {rem_reg, quo_reg[pwl_lin_pkg::QUOT_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign rem_next  = div_ge ? div_diff[FW-1:0] : div_trial[FW-1:0];
    assign quo_next  = {quo_reg[pwl_lin_pkg::QUOT_BITS-2:0], div_ge};

    assign sum_w  = {1'b0, y1_reg} + {1'b0, FW'(quo_next)};
    assign diff_w = {1'b0, y1_reg} - {1'b0, FW'(quo_next)};
    always_comb begin
        if (neg_reg) begin
            res_value = diff_w[FW] ? '0 : diff_w[FW-1:0];
        end else begin
            res_value = sum_w[FW] ? pwl_lin_pkg::FLOW_MAX : sum_w[FW-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (conv_accept) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = den_zero ? ST_DONE : ST_MUL;
                end else if (last) begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL: state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == pwl_lin_pkg::DIV_CNT_W'(pwl_lin_pkg::QUOT_BITS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sens_mem[wr_addr] <= s_entry_sensor;
            flow_mem[wr_addr] <= s_entry_flow;
        end
        sens_q_reg  <= sens_mem[rd_idx_reg];
        flow_q_reg  <= flow_mem[rd_idx_reg];
        valid_q_reg <= valid_reg[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            data_ok_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            data_ok_reg <= (state_reg == ST_SCAN);
            if (wr_en) valid_reg[wr_addr] <= 1'b1;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (conv_accept) begin
                    x_reg      <= s_sample;
                    rd_idx_reg <= '0;
                end
            end
            ST_SCAN: begin
                // advance the read address, saturate at the last entry
                if (rd_idx_reg != LAST_IDX) rd_idx_reg <= rd_idx_reg + 1'b1;
                data_idx_reg <= rd_idx_reg;
                if (data_ok_reg) begin
                    prev_sens_reg <= cur_sens;
                    prev_flow_reg <= cur_flow;
                end
                if (hit) begin
                    y1_reg       <= prev_flow_reg;
                    neg_reg      <= (cur_flow < prev_flow_reg);
                    dy_reg       <= (cur_flow < prev_flow_reg) ? prev_flow_reg - cur_flow
                                                               : cur_flow - prev_flow_reg;
                    dx_reg       <= x_reg - prev_sens_reg;
                    den_reg      <= cur_sens - prev_sens_reg;
                    res_flow_reg <= prev_flow_reg;
                    res_in_reg   <= 1'b1;
                end else if (last) begin
                    res_flow_reg <= '0;
                    res_in_reg   <= 1'b0;
                end
            end
            ST_MUL: begin
                {rem_reg, quo_reg} <= prod;
                div_cnt_reg        <= '0;
            end
            ST_DIV: begin
                rem_reg      <= rem_next;
                quo_reg      <= quo_next;
                div_cnt_reg  <= div_cnt_reg + 1'b1;
                res_flow_reg <= res_value;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_flow_reg <= res_flow_reg;
                    out_in_reg   <= res_in_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_flow_reg};
    assign m_tuser  = out_in_reg;

`ifndef SYNTH
    a_conv_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_accept |=> (state_reg == ST_SCAN))
        else $error("convert transaction did not start the segment scan");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == pwl_lin_pkg::OP_WRITE) && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("table write produced a result");

    a_out_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'h0000))
        else $error("out-of-range result carries nonzero flow");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |->
            (div_cnt_reg < pwl_lin_pkg::DIV_CNT_W'(pwl_lin_pkg::QUOT_BITS)))
        else $error("divider step count overran");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(conv_accept) |-> !s_tready)
        else $error("input taken while a conversion runs");
`endif

endmodule
